// File: rtl/hsp_pkg.sv
// ----------------------------------------------------------------------------
// hsp_pkg
// Shared constants of the hemisphere sample point generator.
// ----------------------------------------------------------------------------
package hsp_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int CORDIC_GAIN = 39797;
	localparam int PUSH_Z = 13107;
	localparam int IDX_W = 8;
	localparam int CNT_W = 9;
	localparam int CNT_RESET = 64;

	// arctangent per step, 2^-16 turn units
	localparam int ATAN_TURNS [CORDIC_STEPS] = '{
		8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0
	};

endpackage

// File: rtl/hsp_div_pipe.sv
// ----------------------------------------------------------------------------
// hsp_div_pipe
// Pipelined restoring divider, one quotient bit per stage, elastic stages.
// ----------------------------------------------------------------------------
module hsp_div_pipe #(
	parameter int NW = 24,
	parameter int DW = 9,
	parameter int PW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [NW-1:0] in_num,
	input  logic [DW-1:0] in_den,
	input  logic [PW-1:0] in_pl,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [NW-1:0] out_quo,
	output logic [PW-1:0] out_pl
);

	logic [NW-1:0] vld_s;
	logic [DW-1:0] rem_s [NW];
	logic [NW-1:0] num_s [NW];
	logic [DW-1:0] den_s [NW];
	logic [PW-1:0] pl_s  [NW];

	logic [NW-1:0] c_vld;
	logic [NW-1:0] rdy;
	logic [DW-1:0] c_rem [NW];
	logic [NW-1:0] c_num [NW];
	logic [DW-1:0] c_den [NW];
	logic [PW-1:0] c_pl  [NW];

	for (genvar k = 0; k < NW; k++) begin : g_st
		logic [DW:0]   t;
		logic          ge;
		if (k == 0) begin : g_src
			assign c_vld[k] = in_valid;
			assign c_rem[k] = '0;
			assign c_num[k] = in_num;
			assign c_den[k] = in_den;
			assign c_pl[k]  = in_pl;
		end else begin : g_src
			assign c_vld[k] = vld_s[k-1];
			assign c_rem[k] = rem_s[k-1];
			assign c_num[k] = num_s[k-1];
			assign c_den[k] = den_s[k-1];
			assign c_pl[k]  = pl_s[k-1];
		end
		if (k == NW-1) begin : g_rdy
			assign rdy[k] = !vld_s[k] || out_ready;
		end else begin : g_rdy
			assign rdy[k] = !vld_s[k] || rdy[k+1];
		end

		assign t  = {c_rem[k], c_num[k][NW-1]};
		assign ge = t >= {1'b0, c_den[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k] <= c_vld[k];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && c_vld[k]) begin
				rem_s[k] <= ge ? DW'(t - {1'b0, c_den[k]}) : t[DW-1:0];
				num_s[k] <= {c_num[k][NW-2:0], ge};
				den_s[k] <= c_den[k];
				pl_s[k]  <= c_pl[k];
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_s[NW-1];
	assign out_quo   = num_s[NW-1];
	assign out_pl    = pl_s[NW-1];

endmodule

// File: rtl/hsp_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// hsp_sqrt_pipe
// Pipelined integer square root (floor), one root bit per stage.
// ----------------------------------------------------------------------------
module hsp_sqrt_pipe #(
	parameter int AW = 32,
	parameter int PW = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [AW-1:0]    in_rad,
	input  logic [PW-1:0]    in_pl,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [AW/2-1:0]  out_root,
	output logic [PW-1:0]    out_pl
);

	localparam int RW = AW / 2;

	logic [RW-1:0] vld_s;
	logic [RW:0]   rem_s  [RW];
	logic [RW-1:0] root_s [RW];
	logic [AW-1:0] rad_s  [RW];
	logic [PW-1:0] pl_s   [RW];

	logic [RW-1:0] c_vld;
	logic [RW-1:0] rdy;
	logic [RW:0]   c_rem  [RW];
	logic [RW-1:0] c_root [RW];
	logic [AW-1:0] c_rad  [RW];
	logic [PW-1:0] c_pl   [RW];

	for (genvar k = 0; k < RW; k++) begin : g_st
		logic [RW+2:0] t;
		logic [RW+2:0] trial;
		logic          ge;
		if (k == 0) begin : g_src
			assign c_vld[k]  = in_valid;
			assign c_rem[k]  = '0;
			assign c_root[k] = '0;
			assign c_rad[k]  = in_rad;
			assign c_pl[k]   = in_pl;
		end else begin : g_src
			assign c_vld[k]  = vld_s[k-1];
			assign c_rem[k]  = rem_s[k-1];
			assign c_root[k] = root_s[k-1];
			assign c_rad[k]  = rad_s[k-1];
			assign c_pl[k]   = pl_s[k-1];
		end
		if (k == RW-1) begin : g_rdy
			assign rdy[k] = !vld_s[k] || out_ready;
		end else begin : g_rdy
			assign rdy[k] = !vld_s[k] || rdy[k+1];
		end

		assign t     = {c_rem[k], c_rad[k][AW-1:AW-2]};
		assign trial = {1'b0, c_root[k], 2'b01};
		assign ge    = t >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k] <= c_vld[k];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && c_vld[k]) begin
				rem_s[k]  <= ge ? (RW+1)'(t - trial) : t[RW:0];
				root_s[k] <= {c_root[k][RW-2:0], ge};
				rad_s[k]  <= {c_rad[k][AW-3:0], 2'b00};
				pl_s[k]   <= c_pl[k];
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_s[RW-1];
	assign out_root  = root_s[RW-1];
	assign out_pl    = pl_s[RW-1];

endmodule

// File: rtl/hemisphere_sample_point_gen.sv
// ----------------------------------------------------------------------------
// hemisphere_sample_point_gen
// Hammersley point to uniform hemisphere direction, z pushed up and normalized.
// ----------------------------------------------------------------------------
// channel  dir  signals                         content
// s_*      in   s_tvalid s_tready s_tdata[7:0]  sample_index
// m_*      out  m_tvalid m_tready m_tdata m_tuser  dir_x/y/z, index_beyond_count
// cfg_*    in   cfg_valid cfg_ready cfg_data    sample_count
//
// One item per cycle while m_tready is high; the path runs through the index divider,
// CORDIC, two root units, the output dividers and three single-register stages.
// Each stage is elastic: a stalled output fills bubbles before s_tready drops.
// Reset clears valid bits and sets sample_count to 64. cfg_ready is always 1.
// ----------------------------------------------------------------------------
module hemisphere_sample_point_gen
	import hsp_pkg::*;
#(
	parameter int MAX_SAMPLES = 256,
	parameter int OUT_FRAC_BITS = 15,
	localparam int W = OUT_FRAC_BITS + 1,
	localparam int DATA_W = ((3 * W + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // [7:0] sample_index
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,   // dir_x, dir_y, dir_z, zero pad
	output logic              m_tuser,   // [0] index_beyond_count
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [8:0]        cfg_data   // [8:0] sample_count
);

	localparam int QW = OUT_FRAC_BITS + 19;

	logic [CNT_W-1:0] sample_count_q;
	logic [CNT_W-1:0] n_eff;
	logic [IDX_W-1:0] rev;
	logic             flag_in;
	logic [16:0]      cos_in;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= CNT_W'(CNT_RESET);
		end else if (cfg_valid) begin
			sample_count_q <= cfg_data;
		end
	end

	always_comb begin
		n_eff = sample_count_q;
		if (sample_count_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (32'(sample_count_q) > MAX_SAMPLES) begin
			n_eff = CNT_W'(MAX_SAMPLES);
		end
		for (int i = 0; i < IDX_W; i++) begin
			rev[i] = s_tdata[IDX_W-1-i];
		end
	end

	assign flag_in = {1'b0, s_tdata} >= n_eff;
	assign cos_in  = 17'h10000 - {1'b0, rev, 8'h00};

	// index divider: phase = (i << 16) / N
	logic        d1_valid;
	logic [23:0] d1_quo;
	logic [17:0] d1_pl;
	logic        rdy_c0;

	hsp_div_pipe #(.NW(24), .DW(CNT_W), .PW(18)) u_div_phase (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.in_num({s_tdata, 16'h0000}), .in_den(n_eff), .in_pl({flag_in, cos_in}),
		.out_valid(d1_valid), .out_ready(rdy_c0),
		.out_quo(d1_quo), .out_pl(d1_pl)
	);

	// CORDIC, rotation mode
	logic                    rdy_s1;
	logic [CORDIC_STEPS-1:0] vld_c;
	logic [CORDIC_STEPS-1:0] rdy_c;
	logic signed [18:0]      cx_s [CORDIC_STEPS];
	logic signed [18:0]      cy_s [CORDIC_STEPS];
	logic signed [17:0]      cz_s [CORDIC_STEPS];
	logic [1:0]              quad_s [CORDIC_STEPS];
	logic [17:0]             cpl_s  [CORDIC_STEPS];

	logic [CORDIC_STEPS-1:0] i_vld;
	logic signed [18:0]      i_x [CORDIC_STEPS];
	logic signed [18:0]      i_y [CORDIC_STEPS];
	logic signed [17:0]      i_z [CORDIC_STEPS];
	logic [1:0]              i_quad [CORDIC_STEPS];
	logic [17:0]             i_pl   [CORDIC_STEPS];

	assign rdy_c0 = rdy_c[0];

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
		logic signed [18:0] dx;
		logic signed [18:0] dy;
		logic               pos;
		if (k == 0) begin : g_src
			assign i_vld[k]  = d1_valid;
			assign i_x[k]    = 19'(CORDIC_GAIN);
			assign i_y[k]    = '0;
			assign i_z[k]    = $signed({4'b0000, d1_quo[13:0]});
			assign i_quad[k] = d1_quo[15:14];
			assign i_pl[k]   = d1_pl;
		end else begin : g_src
			assign i_vld[k]  = vld_c[k-1];
			assign i_x[k]    = cx_s[k-1];
			assign i_y[k]    = cy_s[k-1];
			assign i_z[k]    = cz_s[k-1];
			assign i_quad[k] = quad_s[k-1];
			assign i_pl[k]   = cpl_s[k-1];
		end
		if (k == CORDIC_STEPS-1) begin : g_rdy
			assign rdy_c[k] = !vld_c[k] || rdy_s1;
		end else begin : g_rdy
			assign rdy_c[k] = !vld_c[k] || rdy_c[k+1];
		end

		assign dx  = i_y[k] >>> k;
		assign dy  = i_x[k] >>> k;
		assign pos = !i_z[k][17];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_c[k] <= 1'b0;
			end else if (rdy_c[k]) begin
				vld_c[k] <= i_vld[k];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy_c[k] && i_vld[k]) begin
				cx_s[k]   <= pos ? i_x[k] - dx : i_x[k] + dx;
				cy_s[k]   <= pos ? i_y[k] + dy : i_y[k] - dy;
				cz_s[k]   <= pos ? i_z[k] - 18'(ATAN_TURNS[k]) : i_z[k] + 18'(ATAN_TURNS[k]);
				quad_s[k] <= i_quad[k];
				cpl_s[k]  <= i_pl[k];
			end
		end
	end

	// stage 1: quadrant rotation, cos_theta squared
	localparam int CL = CORDIC_STEPS - 1;
	logic               vld_s1;
	logic signed [18:0] co_s1;
	logic signed [18:0] si_s1;
	logic [16:0]        cos_s1;
	logic [33:0]        csq_s1;
	logic               flag_s1;
	logic               sq1_in_ready;

	assign rdy_s1 = !vld_s1 || sq1_in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy_s1) begin
			vld_s1 <= vld_c[CL];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && vld_c[CL]) begin
			case (quad_s[CL])
				2'd0: begin co_s1 <= cx_s[CL];  si_s1 <= cy_s[CL];  end
				2'd1: begin co_s1 <= -cy_s[CL]; si_s1 <= cx_s[CL];  end
				2'd2: begin co_s1 <= -cx_s[CL]; si_s1 <= -cy_s[CL]; end
				default: begin co_s1 <= cy_s[CL]; si_s1 <= -cx_s[CL]; end
			endcase
			cos_s1  <= cpl_s[CL][16:0];
			csq_s1  <= cpl_s[CL][16:0] * cpl_s[CL][16:0];
			flag_s1 <= cpl_s[CL][17];
		end
	end

	// sin_theta = sqrt(1 - cos_theta^2)
	logic        sq1_valid;
	logic [15:0] sq1_root;
	logic [55:0] sq1_pl;
	logic        rdy_s2;

	hsp_sqrt_pipe #(.AW(32), .PW(56)) u_sqrt_sin (
		.clk(clk), .arst_n(arst_n),
		.in_valid(vld_s1), .in_ready(sq1_in_ready),
		.in_rad(32'(34'h1_0000_0000 - csq_s1)),
		.in_pl({flag_s1, cos_s1, co_s1, si_s1}),
		.out_valid(sq1_valid), .out_ready(rdy_s2),
		.out_root(sq1_root), .out_pl(sq1_pl)
	);

	// stage 2: x, y, z
	logic               vld_s2;
	logic signed [19:0] x_s2;
	logic signed [19:0] y_s2;
	logic [16:0]        z_s2;
	logic               flag_s2;
	logic               rdy_s3;
	logic signed [35:0] px;
	logic signed [35:0] py;

	assign px = $signed(sq1_pl[37:19]) * $signed({1'b0, sq1_root});
	assign py = $signed(sq1_pl[18:0]) * $signed({1'b0, sq1_root});
	assign rdy_s2 = !vld_s2 || rdy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (rdy_s2) begin
			vld_s2 <= sq1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && sq1_valid) begin
			x_s2    <= px[35:16];
			y_s2    <= py[35:16];
			z_s2    <= sq1_pl[54:38] + 17'(PUSH_Z);
			flag_s2 <= sq1_pl[55];
		end
	end

	// stage 3: squares
	logic               vld_s3;
	logic [32:0]        xx_s3;
	logic [32:0]        yy_s3;
	logic [33:0]        zz_s3;
	logic signed [19:0] x_s3;
	logic signed [19:0] y_s3;
	logic [16:0]        z_s3;
	logic               flag_s3;
	logic               sq2_in_ready;
	logic signed [39:0] sxx;
	logic signed [39:0] syy;

	assign sxx = x_s2 * x_s2;
	assign syy = y_s2 * y_s2;
	assign rdy_s3 = !vld_s3 || sq2_in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (rdy_s3) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && vld_s2) begin
			xx_s3   <= sxx[32:0];
			yy_s3   <= syy[32:0];
			zz_s3   <= z_s2 * z_s2;
			x_s3    <= x_s2;
			y_s3    <= y_s2;
			z_s3    <= z_s2;
			flag_s3 <= flag_s2;
		end
	end

	// vector length
	logic        sq2_valid;
	logic [17:0] len;
	logic [57:0] sq2_pl;
	logic        dv_ready;

	hsp_sqrt_pipe #(.AW(36), .PW(58)) u_sqrt_len (
		.clk(clk), .arst_n(arst_n),
		.in_valid(vld_s3), .in_ready(sq2_in_ready),
		.in_rad(36'(xx_s3) + 36'(yy_s3) + 36'(zz_s3)),
		.in_pl({flag_s3, x_s3, y_s3, z_s3}),
		.out_valid(sq2_valid), .out_ready(dv_ready),
		.out_root(len), .out_pl(sq2_pl)
	);

	// normalize: (|c| << F + len/2) / len
	logic signed [19:0] lx;
	logic signed [19:0] ly;
	logic [19:0]        mx;
	logic [19:0]        my;
	logic [QW-1:0]      half;
	logic [QW-1:0]      qx;
	logic [QW-1:0]      qy;
	logic [QW-1:0]      qz;
	logic [1:0]         plx;
	logic               ply;
	logic               plz;
	logic               dx_ready;
	logic               dy_ready;
	logic               dz_ready;
	logic               dx_valid;
	logic               dy_valid;
	logic               dz_valid;

	assign lx   = $signed(sq2_pl[56:37]);
	assign ly   = $signed(sq2_pl[36:17]);
	assign mx   = lx[19] ? 20'(-lx) : 20'(lx);
	assign my   = ly[19] ? 20'(-ly) : 20'(ly);
	assign half = QW'(len[17:1]);

	// the three dividers run in lockstep
	assign dv_ready = dx_ready && dy_ready && dz_ready;
	assign m_tvalid = dx_valid && dy_valid && dz_valid;

	hsp_div_pipe #(.NW(QW), .DW(18), .PW(2)) u_div_x (
		.clk(clk), .arst_n(arst_n),
		.in_valid(sq2_valid), .in_ready(dx_ready),
		.in_num(QW'({mx[17:0], {OUT_FRAC_BITS{1'b0}}}) + half), .in_den(len),
		.in_pl({sq2_pl[57], lx[19]}),
		.out_valid(dx_valid), .out_ready(m_tready),
		.out_quo(qx), .out_pl(plx)
	);

	hsp_div_pipe #(.NW(QW), .DW(18), .PW(1)) u_div_y (
		.clk(clk), .arst_n(arst_n),
		.in_valid(sq2_valid), .in_ready(dy_ready),
		.in_num(QW'({my[17:0], {OUT_FRAC_BITS{1'b0}}}) + half), .in_den(len),
		.in_pl(ly[19]),
		.out_valid(dy_valid), .out_ready(m_tready),
		.out_quo(qy), .out_pl(ply)
	);

	hsp_div_pipe #(.NW(QW), .DW(18), .PW(1)) u_div_z (
		.clk(clk), .arst_n(arst_n),
		.in_valid(sq2_valid), .in_ready(dz_ready),
		.in_num(QW'({1'b0, sq2_pl[16:0], {OUT_FRAC_BITS{1'b0}}}) + half), .in_den(len),
		.in_pl(1'b0),
		.out_valid(dz_valid), .out_ready(m_tready),
		.out_quo(qz), .out_pl(plz)
	);

	function automatic logic [W-1:0] sat(input logic neg, input logic [QW-1:0] q);
		logic [W-1:0] m;
		m = q[W-1:0];
		if (q >= (QW'(1) << OUT_FRAC_BITS)) begin
			return neg ? {1'b1, {OUT_FRAC_BITS{1'b0}}} : {1'b0, {OUT_FRAC_BITS{1'b1}}};
		end
		if (neg) begin
			return W'(-m);
		end
		return m;
	endfunction

	assign m_tdata = DATA_W'({sat(plz, qz), sat(ply, qy), sat(plx[0], qx)});
	assign m_tuser = plx[1];

endmodule

// File: rtl/hsp_checker.sv
// ----------------------------------------------------------------------------
// hsp_checker
// Port-level checks for the hemisphere sample point generator.
// ----------------------------------------------------------------------------
module hsp_checker #(
	parameter int OUT_FRAC_BITS = 15,
	localparam int W = OUT_FRAC_BITS + 1,
	localparam int DATA_W = ((3 * W + 7) / 8) * 8
) (
	input logic              clk,
	input logic              arst_n,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [DATA_W-1:0] m_tdata,
	input logic              m_tuser
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped before transfer");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_z_up: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[3*W-1])
		else $error("dir_z negative");

	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid)
		else $error("result shown right after reset");

endmodule

bind hemisphere_sample_point_gen hsp_checker #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_hsp_checker (
	.clk(clk), .arst_n(arst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
	.m_tdata(m_tdata), .m_tuser(m_tuser)
);

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stream test of hemisphere_sample_point_gen: random bursts of sample indexes
// under several sample counts, each direction predicted in fixed point and
// compared with the output transfers in order.
// ----------------------------------------------------------------------------
module tb;
	import hsp_pkg::*;

	localparam int OFB = 15;
	localparam int W = OFB + 1;
	localparam int DATA_W = ((3 * W + 7) / 8) * 8;
	localparam int LATENCY = 77 + OFB + 19;
	localparam int IDLE_LIMIT = 20000;

	typedef struct packed {
		logic [15:0] dx;
		logic [15:0] dy;
		logic [15:0] dz;
		logic        beyond;
	} dir_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [7:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [DATA_W-1:0] m_tdata;
	logic m_tuser;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [8:0] cfg_data = '0;

	hemisphere_sample_point_gen dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	logic [7:0] index_queue [$];
	dir_t       dir_expected [$];
	int unsigned count_reg = CNT_RESET;
	int errors = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	int gap_left = 0;
	int stall_phase = 0;
	bit stim_done = 0;
	bit in_taken = 0;

	function automatic longint floor_shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint isqrt(longint unsigned n);
		longint unsigned res = 0, bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic logic [15:0] scale_out(longint c, longint len);
		longint mag, q, r;
		mag = c < 0 ? -c : c;
		q = ((mag << OFB) + len / 2) / len;
		if (q > (longint'(1) << (OFB + 1))) q = longint'(1) << (OFB + 1);
		r = c < 0 ? -q : q;
		if (r > (longint'(1) << OFB) - 1) r = (longint'(1) << OFB) - 1;
		if (r < -(longint'(1) << OFB)) r = -(longint'(1) << OFB);
		return r[15:0];
	endfunction

	function automatic dir_t hemisphere_dir(logic [7:0] idx, int unsigned cnt);
		longint n, phase, v, cos_t, sin_t, x, y, z, cx, cy, cz, dxs, dys, cph, sph, len;
		logic [31:0] rev;
		int quad;
		dir_t d;
		n = cnt == 0 ? 1 : (cnt > 256 ? 256 : cnt);
		phase = ((longint'(idx) << 16) / n) & 16'hFFFF;
		for (int i = 0; i < 32; i++) rev[31 - i] = (i < 8) ? idx[i] : 1'b0;
		v = rev[31:16];
		cos_t = 65536 - v;
		sin_t = isqrt((64'd1 << 32) - longint'(cos_t * cos_t));
		quad = int'((phase >> 14) & 3);
		cz = phase & 16'h3FFF;
		cx = CORDIC_GAIN;
		cy = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dxs = floor_shr(cy, i);
			dys = floor_shr(cx, i);
			if (cz >= 0) begin
				cx -= dxs; cy += dys; cz -= ATAN_TURNS[i];
			end else begin
				cx += dxs; cy -= dys; cz += ATAN_TURNS[i];
			end
		end
		case (quad)
			0: begin cph = cx; sph = cy; end
			1: begin cph = -cy; sph = cx; end
			2: begin cph = -cx; sph = -cy; end
			default: begin cph = cy; sph = -cx; end
		endcase
		x = floor_shr(cph * sin_t, 16);
		y = floor_shr(sph * sin_t, 16);
		z = cos_t + PUSH_Z;
		len = isqrt(x * x + y * y + z * z);
		if (len == 0) len = 1;
		d.dx = scale_out(x, len);
		d.dy = scale_out(y, len);
		d.dz = scale_out(z, len);
		d.beyond = longint'(idx) >= n;
		return d;
	endfunction

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || in_taken) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 0;
				end else if (index_queue.size() > 0) begin
					s_tvalid <= 1;
					s_tdata <= index_queue[0];
					if (burst_left > 0) burst_left--;
					else begin
						burst_left = $urandom_range(0, 30);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
					end
				end else begin
					s_tvalid <= 0;
				end
			end
			stall_phase++;
			if (stall_phase % 500 < 150) m_tready <= 1;
			else m_tready <= ((stall_phase * 7) % 11) > 3;
		end
	end

	// monitor
	always @(posedge clk) begin
		dir_t got, want;
		if (arst_n) begin
			in_taken = s_tvalid && s_tready;
			if (in_taken) begin
				dir_expected.push_back(hemisphere_dir(s_tdata, count_reg));
				void'(index_queue.pop_front());
			end
			if ((m_tvalid && m_tready) || in_taken) idle_cycles = 0;
			else if (dir_expected.size() > 0 || index_queue.size() > 0) idle_cycles++;
			if (m_tvalid && m_tready) begin
				got.dx = m_tdata[15:0];
				got.dy = m_tdata[31:16];
				got.dz = m_tdata[47:32];
				got.beyond = m_tuser;
				if (dir_expected.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected transfer %h", got);
				end else begin
					want = dir_expected.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10)
							$display("mismatch exp x=%h y=%h z=%h f=%b got x=%h y=%h z=%h f=%b",
								want.dx, want.dy, want.dz, want.beyond,
								got.dx, got.dy, got.dz, got.beyond);
					end
				end
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	task automatic wait_drained();
		while (index_queue.size() > 0 || s_tvalid || dir_expected.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_count(int unsigned val);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_data <= val[8:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		count_reg = val & 9'h1FF;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	initial begin
		int unsigned counts [8] = '{1, 256, 0, 511, 300, 64, 7, 200};
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		for (int i = 0; i < 20; i++)
			index_queue.push_back(i < 4 ? (i == 0 ? 8'd0 : (i == 1 ? 8'd255 : (i == 2 ? 8'd63 : 8'd64)))
				: 8'(i * 13));
		wait_drained();
		foreach (counts[c]) begin
			write_count(counts[c]);
			index_queue.push_back(8'd0);
			index_queue.push_back(8'd255);
			for (int i = 0; i < 235; i++)
				index_queue.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom)
					: 8'($urandom_range(0, (counts[c] == 0 ? 1 : counts[c]) - 1)));
			wait_drained();
		end
		if (errors == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end
endmodule
